[hdl/ordered_array_edit_engine_core_assert.svh]
// Assertion macros shared by the edit engine modules.
// Needs clk and rst in scope at the point of use.
`ifndef ORDERED_ARRAY_EDIT_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_EDIT_ENGINE_CORE_ASSERT_SVH

// condition holds on every clock
`define OAEE_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OAEE_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define OAEE_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/oaee_pkg.sv]
// Shared constants, codes and controller/datapath structs for the edit engine.
// No dependencies.
package oaee_pkg;

  localparam int CAPACITY = 64;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int LANE     = 8;
  localparam int LANE_W   = $clog2(LANE);
  localparam int GROUPS   = CAPACITY / LANE;
  localparam int GRP_W    = $clog2(GROUPS);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_DISPLAY = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    EMIT_PLAIN   = 2'd0,
    EMIT_SEARCH  = 2'd1,
    EMIT_DISPLAY = 2'd2
  } emit_kind_t;

  typedef struct packed {
    logic       latch;
    logic       do_insert;
    logic       do_delete;
    logic       do_replace;
    logic       match_cap;
    logic       group_cap;
    logic       rotate;
    logic       emit;
    emit_kind_t kind;
    status_t    status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic empty;
    logic full;
    logic out_free;
    logic disp_last;
  } stat_t;

endpackage

[hdl/oaee_req_if.sv]
// Request channel: one word per operation (valid/ready).
// Depends on oaee_pkg.
interface oaee_req_if;
  logic                               valid;
  logic                               ready;
  logic [oaee_pkg::OP_W-1:0]          operation;
  logic [oaee_pkg::POS_W-1:0]         position;
  logic signed [oaee_pkg::DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

[hdl/oaee_rsp_if.sv]
// Result channel: one word per result (valid/ready).
// Depends on oaee_pkg.
interface oaee_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [oaee_pkg::STATUS_W-1:0]      status;
  logic [oaee_pkg::IDX_W-1:0]         index;
  logic signed [oaee_pkg::DATA_W-1:0] data;
  logic [oaee_pkg::CNT_W-1:0]         count;
  logic                               last;

  modport source (output valid, status, index, data, count, last, input ready);
  modport sink   (input valid, status, index, data, count, last, output ready);
endinterface

[hdl/oaee_ctrl.sv]
// Controller state machine for the edit engine.
// Depends on oaee_pkg and the assertion header; talks to oaee_datapath via cmd/stat.
`include "ordered_array_edit_engine_core_assert.svh"

module oaee_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  oaee_pkg::stat_t stat,
  output oaee_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MATCH  = 6'b000100,
    S_FIND   = 6'b001000,
    S_DISP   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t            state, state_next;
  oaee_pkg::status_t status_q, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
  end

  always_comb begin
    cmd         = '0;
    cmd.kind    = oaee_pkg::EMIT_PLAIN;
    cmd.status  = status_q;
    state_next  = state;
    status_next = status_q;
    req_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_EMIT;
        unique case (stat.op)
          oaee_pkg::OP_INSERT: begin
            if (stat.pos_gt_cnt) begin
              status_next = oaee_pkg::ST_BAD_POS;
            end else if (stat.full) begin
              status_next = oaee_pkg::ST_FULL;
            end else begin
              status_next   = oaee_pkg::ST_OK;
              cmd.do_insert = 1'b1;
            end
          end
          oaee_pkg::OP_DELETE: begin
            if (stat.empty) begin
              status_next = oaee_pkg::ST_EMPTY;
            end else if (stat.pos_ge_cnt) begin
              status_next = oaee_pkg::ST_BAD_POS;
            end else begin
              status_next   = oaee_pkg::ST_OK;
              cmd.do_delete = 1'b1;
            end
          end
          oaee_pkg::OP_REPLACE: begin
            if (stat.empty) begin
              status_next = oaee_pkg::ST_EMPTY;
            end else if (stat.pos_ge_cnt) begin
              status_next = oaee_pkg::ST_BAD_POS;
            end else begin
              status_next    = oaee_pkg::ST_OK;
              cmd.do_replace = 1'b1;
            end
          end
          oaee_pkg::OP_SEARCH: begin
            cmd.match_cap = 1'b1;
            state_next    = S_MATCH;
          end
          oaee_pkg::OP_DISPLAY: begin
            if (stat.empty) begin
              status_next = oaee_pkg::ST_EMPTY;
            end else begin
              state_next = S_DISP;
            end
          end
          default: begin
            status_next = oaee_pkg::ST_OK;
          end
        endcase
      end
      S_MATCH: begin
        cmd.group_cap = 1'b1;
        state_next    = S_FIND;
      end
      S_FIND: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = oaee_pkg::EMIT_SEARCH;
          state_next = S_IDLE;
        end
      end
      S_DISP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = oaee_pkg::EMIT_DISPLAY;
          cmd.rotate = 1'b1;
          if (stat.disp_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `OAEE_CHECK_IMP(a_emit_free, cmd.emit, stat.out_free, "result loaded while output busy")
  `OAEE_CHECK_NXT(a_accept_decode, req_valid && req_ready, state == S_DECODE, "accept not decoded")
  `OAEE_CHECK(a_one_edit, $onehot0({cmd.do_insert, cmd.do_delete, cmd.do_replace, cmd.rotate, cmd.match_cap}), "conflicting edit commands")

endmodule

[hdl/oaee_datapath.sv]
// Datapath: cell chain of entries, count, search reduction and result register.
// Depends on oaee_pkg, oaee_rsp_if and the assertion header; driven by oaee_ctrl.
`include "ordered_array_edit_engine_core_assert.svh"

module oaee_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [oaee_pkg::OP_W-1:0]          operation,
  input  logic [oaee_pkg::POS_W-1:0]         position,
  input  logic signed [oaee_pkg::DATA_W-1:0] value,
  oaee_rsp_if.source                         rsp,
  input  oaee_pkg::cmd_t                     cmd,
  output oaee_pkg::stat_t                    stat
);

  localparam int CAP   = oaee_pkg::CAPACITY;
  localparam int CNT_W = oaee_pkg::CNT_W;
  localparam int IDX_W = oaee_pkg::IDX_W;
  localparam int LANE  = oaee_pkg::LANE;
  localparam int GRPS  = oaee_pkg::GROUPS;

  logic signed [oaee_pkg::DATA_W-1:0] slot [CAP];
  oaee_pkg::op_t                      op_q;
  logic [oaee_pkg::POS_W-1:0]         pos_q;
  logic signed [oaee_pkg::DATA_W-1:0] value_q;
  logic [CNT_W-1:0]                   count;
  logic [CAP-1:0]                     match_q;
  logic [GRPS-1:0]                    grp_any;
  logic [oaee_pkg::LANE_W-1:0]        grp_low [GRPS];
  logic [IDX_W-1:0]                   disp_idx;
  logic                               found;
  logic [IDX_W-1:0]                   found_idx;

  logic                               out_valid;
  oaee_pkg::status_t                  out_status;
  logic [IDX_W-1:0]                   out_index;
  logic signed [oaee_pkg::DATA_W-1:0] out_data;
  logic [CNT_W-1:0]                   out_count;
  logic                               out_last;

  function automatic logic [oaee_pkg::LANE_W-1:0] lane_first(input logic [LANE-1:0] m);
    logic [oaee_pkg::LANE_W-1:0] r;
    r = '0;
    for (int k = LANE - 1; k >= 0; k--) begin
      if (m[k]) r = oaee_pkg::LANE_W'(k);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= oaee_pkg::op_t'(operation);
      pos_q   <= position;
      value_q <= value;
    end
  end

  // cell chain: each entry loads from its neighbors, from entry 0 on the rotate wrap, or from the latched value
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [CNT_W-1:0] I = CNT_W'(i);
    logic signed [oaee_pkg::DATA_W-1:0] prev, nxt;
    if (i == 0) begin : g_first
      assign prev = slot[i];
    end else begin : g_mid_lo
      assign prev = slot[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign nxt = slot[0];
    end else begin : g_mid_hi
      assign nxt = slot[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (pos_q == I) begin
          slot[i] <= value_q;
        end else if (I > pos_q && I <= count) begin
          slot[i] <= prev;
        end
      end else if (cmd.do_delete) begin
        if (I >= pos_q && (I + CNT_W'(1)) < count) begin
          slot[i] <= nxt;
        end
      end else if (cmd.do_replace) begin
        if (pos_q == I) begin
          slot[i] <= value_q;
        end
      end else if (cmd.rotate) begin
        if ((I + CNT_W'(1)) < count) begin
          slot[i] <= nxt;
        end else if ((I + CNT_W'(1)) == count) begin
          slot[i] <= slot[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.do_delete) begin
      count <= count - CNT_W'(1);
    end
  end

  // search: compare all, then reduce per lane group, then across groups
  always_ff @(posedge clk) begin
    if (cmd.match_cap) begin
      for (int i = 0; i < CAP; i++) begin
        match_q[i] <= (slot[i] == value_q) && (CNT_W'(i) < count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.group_cap) begin
      for (int g = 0; g < GRPS; g++) begin
        grp_any[g] <= |match_q[g*LANE +: LANE];
        grp_low[g] <= lane_first(match_q[g*LANE +: LANE]);
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found     = 1'b1;
        found_idx = {oaee_pkg::GRP_W'(g), grp_low[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      disp_idx <= '0;
    end else if (cmd.rotate) begin
      disp_idx <= disp_idx + IDX_W'(1);
    end
  end

  assign stat.op         = op_q;
  assign stat.pos_gt_cnt = pos_q > count;
  assign stat.pos_ge_cnt = pos_q >= count;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count >= CNT_W'(CAP));
  assign stat.out_free   = !out_valid || rsp.ready;
  assign stat.disp_last  = ((CNT_W'(disp_idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count <= count;
      case (cmd.kind)
        oaee_pkg::EMIT_SEARCH: begin
          out_status <= found ? oaee_pkg::ST_OK : oaee_pkg::ST_NOT_FOUND;
          out_index  <= found_idx;
          out_data   <= '0;
          out_last   <= 1'b1;
        end
        oaee_pkg::EMIT_DISPLAY: begin
          out_status <= oaee_pkg::ST_OK;
          out_index  <= disp_idx;
          out_data   <= slot[0];
          out_last   <= stat.disp_last;
        end
        default: begin
          out_status <= cmd.status;
          out_index  <= '0;
          out_data   <= '0;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.index  = out_index;
  assign rsp.data   = out_data;
  assign rsp.count  = out_count;
  assign rsp.last   = out_last;

  `OAEE_CHECK(a_count_cap, count <= CNT_W'(CAP), "entry count above capacity")
  `OAEE_CHECK_NXT(a_insert_inc, cmd.do_insert, count == $past(count) + CNT_W'(1), "insert count")
  `OAEE_CHECK_NXT(a_delete_dec, cmd.do_delete, count == $past(count) - CNT_W'(1), "delete count")

endmodule

[hdl/ordered_array_edit_engine_core.sv]
// Ordered array edit engine, top level.
// Depends on oaee_pkg, oaee_req_if, oaee_rsp_if, oaee_ctrl and oaee_datapath.
//
// Usage:
//   req carries one word per operation (operation, position, value); rsp returns
//   result words (status, index, data, count, last), valid/ready on both sides.
//   One operation is in flight at a time; req.ready is high only while idle.
//   Edits (insert, delete, replace) and unused codes pass through a decode
//   state and an emit state, then return to idle for the next word.
//   Search: all entries are compared at once into a match register, reduced
//   per lane group into a register, then across groups into the result word.
//   Display: one result per entry, one per cycle out of the rotating cell chain
//   while rsp.ready stays high; an empty list gives a single word.
//   Every operation ends with a result whose last bit is set.
//   Results sit in an output register; while rsp.ready is low the engine holds
//   that word and waits, without losing or repeating anything.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   no clearing pass is needed, entries above the count are never read.
module ordered_array_edit_engine_core (
  input  logic       clk,
  input  logic       rst,
  oaee_req_if.sink   req,
  oaee_rsp_if.source rsp
);

  oaee_pkg::cmd_t  cmd;
  oaee_pkg::stat_t stat;

  oaee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oaee_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .operation (req.operation),
    .position  (req.position),
    .value     (req.value),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
